### hdl/max_priority_queue_macros.svh
// Assertion macros used by the priority queue datapath.
`ifndef MAX_PRIORITY_QUEUE_MACROS_SVH
`define MAX_PRIORITY_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPQ_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MPQ_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/mpq_pkg.sv
// Shared constants, codes and control types of the priority queue.
package mpq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    localparam int ID_W     = 15;
    localparam int PRIO_W   = 16;
    localparam int STAT_W   = 2;
    localparam int OCC_W    = 5;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic              load;
        logic              insert;
        logic              extract;
        logic [STAT_W-1:0] status;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_stat;

endpackage

### hdl/mpq_datapath.sv
// Sorted entry store, fill count and result register of the priority queue.
`include "max_priority_queue_macros.svh"

module mpq_datapath
    import mpq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic [ID_W-1:0]          i_entry_id,
    input  logic signed [PRIO_W-1:0] i_priority_req,
    output t_stat                    o_stat,
    output logic [STAT_W-1:0]        o_status,
    output logic [ID_W-1:0]          o_out_id,
    output logic signed [PRIO_W-1:0] o_out_priority,
    output logic [OCC_W-1:0]         o_occupancy
);

    logic signed [PRIO_W-1:0] r_prio [CAPACITY];
    logic [ID_W-1:0]          r_id   [CAPACITY];
    logic signed [PRIO_W-1:0] n_prio [CAPACITY];
    logic [ID_W-1:0]          n_id   [CAPACITY];
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [CAPACITY-1:0]      gt;
    logic [IDX_W-1:0]         top_idx;

    logic [STAT_W-1:0]        r_status;
    logic [ID_W-1:0]          r_out_id;
    logic signed [PRIO_W-1:0] r_out_prio;
    logic [OCC_W-1:0]         r_occ;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(CAPACITY));
    assign top_idx      = IDX_W'(r_count - CNT_W'(1));

    // Each cell either keeps its entry, takes the new one or takes its lower neighbour.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            gt[i] = (CNT_W'(i) < r_count) && (r_prio[i] > i_priority_req);
        end
        for (int i = 0; i < CAPACITY; i++) begin
            n_prio[i] = r_prio[i];
            n_id[i]   = r_id[i];
            if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
                n_prio[i] = r_prio[(i > 0) ? i - 1 : 0];
                n_id[i]   = r_id[(i > 0) ? i - 1 : 0];
            end else if (gt[i] || CNT_W'(i) == r_count) begin
                n_prio[i] = i_priority_req;
                n_id[i]   = i_entry_id;
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.extract) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_prio[i] <= n_prio[i];
                r_id[i]   <= n_id[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status <= i_cmd.status;
            r_occ    <= OCC_W'(n_count);
            if (i_cmd.extract) begin
                r_out_id   <= r_id[top_idx];
                r_out_prio <= r_prio[top_idx];
            end else begin
                r_out_id   <= '0;
                r_out_prio <= '0;
            end
        end
    end

    assign o_status       = r_status;
    assign o_out_id       = r_out_id;
    assign o_out_priority = r_out_prio;
    assign o_occupancy    = r_occ;

    `MPQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY))
    `MPQ_ASSERT_NOW(a_no_bad_insert, i_clk, i_rst_n, i_cmd.insert, !o_stat.full && !i_cmd.extract)
    `MPQ_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, i_cmd.insert,
        r_count == $past(r_count) + CNT_W'(1))

endmodule

### hdl/mpq_controller.sv
// Handshake controller that accepts words and issues store commands.
module mpq_controller
    import mpq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_opcode,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output logic  o_out_valid,
    output t_cmd  o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RESP = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_RESP);
    assign accept      = o_in_ready && i_in_valid;

    always_comb begin
        o_cmd.load    = accept;
        o_cmd.insert  = accept && (i_opcode == OP_INSERT) && !i_stat.full;
        o_cmd.extract = accept && (i_opcode == OP_EXTRACT) && !i_stat.empty;
        o_cmd.status  = STAT_OK;
        if (i_opcode == OP_INSERT && i_stat.full) begin
            o_cmd.status = STAT_FULL;
        end else if (i_opcode == OP_EXTRACT && i_stat.empty) begin
            o_cmd.status = STAT_EMPTY;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/max_priority_queue.sv
// A result word is offered in the cycle after its input word is accepted; the
// controller holds one item from acceptance until its result word is taken, and
// accepts no new word before that.
// Reset is synchronous and active low; it empties the queue and clears the
// handshake state. The entry store itself is not cleared.
module max_priority_queue
    import mpq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // entry_id[14:0], priority_req[30:15], zero pad
    input  logic        s_axis_tuser,  // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // out_id[14:0], out_priority[30:15], occupancy[35:31]
    output logic [1:0]  m_axis_tuser   // status
);

    t_cmd                     cmd;
    t_stat                    stat;
    logic [STAT_W-1:0]        status;
    logic [ID_W-1:0]          out_id;
    logic signed [PRIO_W-1:0] out_prio;
    logic [OCC_W-1:0]         occ;

    mpq_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_opcode    (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    mpq_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_entry_id     (s_axis_tdata[14:0]),
        .i_priority_req (s_axis_tdata[30:15]),
        .o_stat         (stat),
        .o_status       (status),
        .o_out_id       (out_id),
        .o_out_priority (out_prio),
        .o_occupancy    (occ)
    );

    assign m_axis_tdata = {4'b0000, occ, out_prio, out_id};
    assign m_axis_tuser = status;

endmodule
